FILE: hw/rtl/srr_sack_pkg.sv
package srr_sack_pkg;

    localparam int REORDER_SLOTS_DEF = 32;
    localparam int SACK_BLOCKS_DEF   = 4;

    // Result kinds carried in the kind field.
    localparam logic [2:0] KIND_DELIVER = 3'd0;
    localparam logic [2:0] KIND_ACK     = 3'd1;
    localparam logic [2:0] KIND_SACK    = 3'd2;
    localparam logic [2:0] KIND_SYNACK  = 3'd3;
    localparam logic [2:0] KIND_FIN     = 3'd4;

    typedef struct packed {
        logic        checksum_ok;
        logic        syn_flag;
        logic        fin_flag;
        logic        other_flags;
        logic [31:0] seq_number;
        logic [15:0] payload_tag;
        logic [15:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_tag;
        logic [15:0] out_length;
        logic [31:0] ack_number;
        logic [5:0]  free_slots;
        logic [2:0]  sack_count;
        logic [31:0] block_start;
        logic [31:0] block_end;
        logic        last;
    } out_item_t;

    // Which result the datapath loads into the output register.
    typedef enum logic [2:0] {
        SRC_DELIV_IN,
        SRC_DELIV_MEM,
        SRC_ACK,
        SRC_ACK_ZERO,
        SRC_FIN,
        SRC_SYNACK,
        SRC_SACK
    } emit_src_t;

    typedef struct packed {
        logic      load;
        logic      clear;
        logic      store;
        logic      advance;
        logic      drain_rd;
        logic      drain_pop;
        logic      scan_start;
        logic      scan_step;
        logic      sack_start;
        logic      sack_next;
        logic      emit;
        emit_src_t emit_src;
    } ctrl_cmd_t;

    typedef struct packed {
        logic chk;
        logic syn;
        logic fin;
        logic data_ok;
        logic d_zero;
        logic in_win;
        logic head_valid;
        logic scan_last;
        logic runs_zero;
        logic sack_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/srr_sack_ctrl.sv
module srr_sack_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  srr_sack_pkg::dp_status_t st,
    output srr_sack_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        IDLE, DECIDE, SYNACK, FINACK, FINOUT, DELIV_IN, DRAIN_CHK, DRAIN_OUT,
        SCAN_INIT, SCAN, ACK, SACK
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == IDLE);

    always_comb begin
        cmd        = '0;
        cmd.emit_src = srr_sack_pkg::SRC_ACK;
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = DECIDE;
                end
            end
            DECIDE: begin
                if (!st.chk) begin
                    state_next = IDLE;
                end else if (st.syn) begin
                    cmd.clear  = 1'b1;
                    state_next = SYNACK;
                end else if (st.fin) begin
                    state_next = FINACK;
                end else if (!st.data_ok) begin
                    state_next = IDLE;
                end else if (st.d_zero) begin
                    state_next = DELIV_IN;
                end else begin
                    cmd.store  = st.in_win;
                    state_next = SCAN_INIT;
                end
            end
            SYNACK: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = srr_sack_pkg::SRC_SYNACK;
                    state_next   = IDLE;
                end
            end
            FINACK: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = srr_sack_pkg::SRC_ACK_ZERO;
                    state_next   = FINOUT;
                end
            end
            FINOUT: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = srr_sack_pkg::SRC_FIN;
                    state_next   = IDLE;
                end
            end
            DELIV_IN: begin
                if (st.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = srr_sack_pkg::SRC_DELIV_IN;
                    cmd.advance  = 1'b1;
                    state_next   = DRAIN_CHK;
                end
            end
            DRAIN_CHK: begin
                if (st.head_valid) begin
                    cmd.drain_rd = 1'b1;
                    state_next   = DRAIN_OUT;
                end else begin
                    state_next = SCAN_INIT;
                end
            end
            DRAIN_OUT: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = srr_sack_pkg::SRC_DELIV_MEM;
                    cmd.drain_pop = 1'b1;
                    state_next    = DRAIN_CHK;
                end
            end
            SCAN_INIT: begin
                cmd.scan_start = 1'b1;
                state_next     = SCAN;
            end
            SCAN: begin
                cmd.scan_step = 1'b1;
                if (st.scan_last) begin
                    state_next = ACK;
                end
            end
            ACK: begin
                if (st.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_src   = srr_sack_pkg::SRC_ACK;
                    cmd.sack_start = 1'b1;
                    state_next     = st.runs_zero ? IDLE : SACK;
                end
            end
            SACK: begin
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = srr_sack_pkg::SRC_SACK;
                    cmd.sack_next = 1'b1;
                    if (st.sack_last) begin
                        state_next = IDLE;
                    end
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> st.out_free) else $error("result loaded over a waiting one");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == DECIDE)) else $error("accepted item not decided");
    a_store_win: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> (st.in_win && !st.d_zero)) else $error("store outside window");
`endif

endmodule

FILE: hw/rtl/srr_sack_dp.sv
module srr_sack_dp #(
    parameter int REORDER_SLOTS = srr_sack_pkg::REORDER_SLOTS_DEF,
    parameter int SACK_BLOCKS   = srr_sack_pkg::SACK_BLOCKS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  srr_sack_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output srr_sack_pkg::out_item_t m_item,
    input  srr_sack_pkg::ctrl_cmd_t  cmd,
    output srr_sack_pkg::dp_status_t st
);

    localparam int IW = $clog2(REORDER_SLOTS);
    localparam int CW = $clog2(REORDER_SLOTS + 1);
    localparam int RW = $clog2(SACK_BLOCKS + 1);
    localparam int SW = (SACK_BLOCKS > 1) ? $clog2(SACK_BLOCKS) : 1;
    localparam logic [IW-1:0] LAST_D = IW'(REORDER_SLOTS - 1);

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                               input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IW+1)'(REORDER_SLOTS)) begin
            s = s - (IW+1)'(REORDER_SLOTS);
        end
        return s[IW-1:0];
    endfunction

    srr_sack_pkg::in_item_t  pkt_reg;
    srr_sack_pkg::out_item_t out_reg, out_next;
    logic                    m_valid_reg;

    logic [31:0]              expected_reg;
    logic [IW-1:0]            head_reg;
    logic [REORDER_SLOTS-1:0] valid_reg;
    logic [CW-1:0]            count_reg;

    logic [31:0] mem [REORDER_SLOTS];
    logic [31:0] rd_data_reg;

    logic [IW-1:0] scan_d_reg;
    logic [31:0]   scan_seq_reg;
    logic [RW-1:0] runs_reg;
    logic          in_run_reg;
    logic [31:0]   run_start_reg [SACK_BLOCKS];
    logic [31:0]   run_end_reg   [SACK_BLOCKS];
    logic [SW-1:0] sack_i_reg;

    logic [31:0]   d_full;
    logic [IW-1:0] store_idx;
    logic [IW-1:0] scan_idx;
    logic          scan_hit;
    logic [RW-1:0] runs_m1;
    logic [IW-1:0] head_inc;
    logic [CW-1:0] free_full;

    assign d_full    = pkt_reg.seq_number - expected_reg;
    assign store_idx = wrap_add(head_reg, d_full[IW-1:0]);
    assign scan_idx  = wrap_add(head_reg, scan_d_reg);
    assign scan_hit  = valid_reg[scan_idx];
    assign runs_m1   = runs_reg - RW'(1);
    assign head_inc  = (head_reg == LAST_D) ? '0 : head_reg + IW'(1);
    assign free_full = CW'(REORDER_SLOTS) - count_reg;

    always_comb begin
        st.chk        = pkt_reg.checksum_ok;
        st.syn        = pkt_reg.syn_flag;
        st.fin        = pkt_reg.fin_flag;
        st.data_ok    = (pkt_reg.payload_length != 16'd0) || !pkt_reg.other_flags;
        st.d_zero     = (d_full == 32'd0);
        st.in_win     = (d_full != 32'd0) && (d_full < 32'(REORDER_SLOTS));
        st.head_valid = valid_reg[head_reg];
        st.scan_last  = (scan_d_reg == LAST_D);
        st.runs_zero  = (runs_reg == '0);
        st.sack_last  = ((RW'(sack_i_reg) + RW'(1)) == runs_reg);
        st.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        out_next = '0;
        case (cmd.emit_src)
            srr_sack_pkg::SRC_DELIV_IN: begin
                out_next.kind       = srr_sack_pkg::KIND_DELIVER;
                out_next.out_tag    = pkt_reg.payload_tag;
                out_next.out_length = pkt_reg.payload_length;
            end
            srr_sack_pkg::SRC_DELIV_MEM: begin
                out_next.kind       = srr_sack_pkg::KIND_DELIVER;
                out_next.out_tag    = rd_data_reg[31:16];
                out_next.out_length = rd_data_reg[15:0];
            end
            srr_sack_pkg::SRC_ACK: begin
                out_next.kind       = srr_sack_pkg::KIND_ACK;
                out_next.ack_number = expected_reg;
                out_next.free_slots = 6'(free_full);
                out_next.sack_count = 3'(runs_reg);
                out_next.last       = (runs_reg == '0);
            end
            srr_sack_pkg::SRC_ACK_ZERO: begin
                out_next.kind = srr_sack_pkg::KIND_ACK;
            end
            srr_sack_pkg::SRC_FIN: begin
                out_next.kind = srr_sack_pkg::KIND_FIN;
                out_next.last = 1'b1;
            end
            srr_sack_pkg::SRC_SYNACK: begin
                out_next.kind = srr_sack_pkg::KIND_SYNACK;
                out_next.last = 1'b1;
            end
            srr_sack_pkg::SRC_SACK: begin
                out_next.kind        = srr_sack_pkg::KIND_SACK;
                out_next.block_start = run_start_reg[sack_i_reg];
                out_next.block_end   = run_end_reg[sack_i_reg];
                out_next.last        = st.sack_last;
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            expected_reg <= 32'd1;
            head_reg     <= '0;
            valid_reg    <= '0;
            count_reg    <= '0;
            runs_reg     <= '0;
            in_run_reg   <= 1'b0;
            scan_d_reg   <= '0;
            sack_i_reg   <= '0;
        end else begin
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.clear) begin
                expected_reg <= 32'd1;
                head_reg     <= '0;
                valid_reg    <= '0;
                count_reg    <= '0;
            end
            if (cmd.store) begin
                if (!valid_reg[store_idx]) begin
                    count_reg <= count_reg + CW'(1);
                end
                valid_reg[store_idx] <= 1'b1;
            end
            if (cmd.advance || cmd.drain_pop) begin
                expected_reg <= expected_reg + 32'd1;
                head_reg     <= head_inc;
            end
            if (cmd.drain_pop) begin
                valid_reg[head_reg] <= 1'b0;
                if (count_reg != '0) begin
                    count_reg <= count_reg - CW'(1);
                end
            end
            if (cmd.scan_start) begin
                scan_d_reg <= IW'(1);
                runs_reg   <= '0;
                in_run_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                scan_d_reg <= scan_d_reg + IW'(1);
                if (!scan_hit) begin
                    in_run_reg <= 1'b0;
                end else if (!in_run_reg && (runs_reg < RW'(SACK_BLOCKS))) begin
                    runs_reg   <= runs_reg + RW'(1);
                    in_run_reg <= 1'b1;
                end
            end
            if (cmd.sack_start) begin
                sack_i_reg <= '0;
            end
            if (cmd.sack_next) begin
                sack_i_reg <= sack_i_reg + SW'(1);
            end
        end
    end

    // Payload registers and the reorder memory.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pkt_reg <= s_item;
        end
        if (cmd.emit) begin
            out_reg <= out_next;
        end
        if (cmd.store) begin
            mem[store_idx] <= {pkt_reg.payload_tag, pkt_reg.payload_length};
        end
        if (cmd.drain_rd) begin
            rd_data_reg <= mem[head_reg];
        end
        if (cmd.scan_start) begin
            scan_seq_reg <= expected_reg + 32'd1;
        end
        if (cmd.scan_step) begin
            scan_seq_reg <= scan_seq_reg + 32'd1;
            if (scan_hit) begin
                if (in_run_reg) begin
                    run_end_reg[runs_m1[SW-1:0]] <= scan_seq_reg;
                end else if (runs_reg < RW'(SACK_BLOCKS)) begin
                    run_start_reg[runs_reg[SW-1:0]] <= scan_seq_reg;
                    run_end_reg[runs_reg[SW-1:0]]   <= scan_seq_reg;
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(count_reg)) else $error("buffered count drift");
    a_runs_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        runs_reg <= RW'(SACK_BLOCKS)) else $error("too many sack runs");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.drain_rd |=> valid_reg[head_reg]) else $error("draining an empty slot");
`endif

endmodule

FILE: hw/rtl/selective_repeat_receiver_sack_unit.sv
// Selective-repeat receiver with SACK reporting.
// The s_ channel takes one packet descriptor per item; the m_ channel gives
// the result items it causes: deliveries, one ACK, then up to SACK_BLOCKS
// SACK run items, or a SYN-ACK, or an ACK and FIN pair. The last flag marks
// the final result of each input item; bad checksums produce no result.
// A new input item is taken only once the previous one has finished; a
// finished result may still wait in the output register at that point.
// An in-order data packet is taken in idle, then decoded and delivered, and
// the drain check follows; each buffered packet that is then in order is read
// and delivered, the slot bitmap is scanned (one slot per cycle), and then
// the ACK and SACK items are given. An out-of-order data packet is decoded,
// stored if it lies in the window, scanned the same way and acknowledged;
// a SYN gives its SYN-ACK, a FIN its ACK and FIN pair, and a dropped packet none.
// Reset (aresetn low, synchronous) sets the expected sequence to one and
// clears all slot valid bits at once; slot payload memory is not cleared.
// When the downstream side holds m_ready low the controller waits with the
// next result, holding all state, and the input side stays not ready.
module selective_repeat_receiver_sack_unit #(
    parameter int REORDER_SLOTS = srr_sack_pkg::REORDER_SLOTS_DEF,
    parameter int SACK_BLOCKS   = srr_sack_pkg::SACK_BLOCKS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  srr_sack_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output srr_sack_pkg::out_item_t m_item
);

    srr_sack_pkg::ctrl_cmd_t  cmd;
    srr_sack_pkg::dp_status_t st;

    // The controller sequences each item; the datapath holds the window state.
    srr_sack_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    srr_sack_dp #(
        .REORDER_SLOTS (REORDER_SLOTS),
        .SACK_BLOCKS   (SACK_BLOCKS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .cmd     (cmd),
        .st      (st)
    );

endmodule
